[hdl/plist_pkg.sv]
// Package for the positional list block: sizes, operation codes and the
// per-cell command types. No dependencies.
`timescale 1ns / 1ps

package plist_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ENTRY_WIDTH = 32;
  localparam int unsigned IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned DATA_W      = 32;
  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(16);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SET    = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_TAKE_PREV = 2'd2,
    CELL_TAKE_NEXT = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e              cmd;
    logic [ENTRY_WIDTH-1:0] data;
  } cell_ctrl_t;

endpackage

[hdl/plist_cell.sv]
// One storage cell of the list: holds one entry and loads, shifts from a
// neighbor or holds on each cycle. Depends on plist_pkg.
`timescale 1ns / 1ps

module plist_cell import plist_pkg::*; (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [ENTRY_WIDTH-1:0] prev_i,
  input  logic [ENTRY_WIDTH-1:0] next_i,
  output logic [ENTRY_WIDTH-1:0] entry_o
);

  logic [ENTRY_WIDTH-1:0] entry_q;
  logic [ENTRY_WIDTH-1:0] entry_d;

  always_comb begin
    case (ctrl_i.cmd)
      CELL_LOAD:      entry_d = ctrl_i.data;
      CELL_TAKE_PREV: entry_d = prev_i;
      CELL_TAKE_NEXT: entry_d = next_i;
      default:        entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hdl/positional_list_insert_remove.sv]
// Top level of the positional list: a row of plist_cell storage cells, the
// length and capacity registers, and the registered result beat.
// Depends on plist_pkg and plist_cell.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   op_i, position_i, entry_data_i
//   out      output     out_valid_o / out_ready_i ok_o, read_value_o, count_o,
//                                                 full_res_o, empty_res_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (capacity_limit)
//
// Each beat is executed in the cycle it is accepted; all cells shift at once.
// The result beat appears in the cycle after acceptance, from the output register.
// One beat per cycle while out_ready_i is high; the output register stalls
// the input only while a result waits and out_ready_i is low.
// Reset clears the length and sets the capacity to 16; entries are not cleared.
`timescale 1ns / 1ps

module positional_list_insert_remove import plist_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [LEN_W-1:0]  position_i,
  input  logic [DATA_W-1:0] entry_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [DATA_W-1:0] read_value_o,
  output logic [LEN_W-1:0]  count_o,
  output logic              full_res_o,
  output logic              empty_res_o
);

  logic [LEN_W-1:0] cap_q;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cap_eff;
  logic             out_valid_q;
  logic             ok_q;
  logic [DATA_W-1:0] rd_q;
  logic [LEN_W-1:0] count_q;
  logic             full_q;
  logic             empty_q;

  logic             in_fire;
  op_e              op;
  logic             pos_ok;
  logic             ins_ok;
  logic             acc_ok;
  logic             op_ok;
  logic [ENTRY_WIDTH-1:0] data_in;
  logic [ENTRY_WIDTH-1:0] rd_entry;
  logic [DATA_W-1:0]      rd_val;

  logic [ENTRY_WIDTH-1:0] entry [DEPTH];
  cell_ctrl_t             ctrl  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = op_e'(op_i);
  assign data_in    = entry_data_i[ENTRY_WIDTH-1:0];

  assign cap_eff = (cap_q > DEPTH_LEN) ? DEPTH_LEN : cap_q;
  assign pos_ok  = !((position_i > len_q) || (position_i == cap_eff));
  assign ins_ok  = pos_ok && (len_q < cap_eff) && (len_q < DEPTH_LEN);
  assign acc_ok  = pos_ok && (position_i < len_q);

  always_comb begin
    case (op)
      OP_INSERT: op_ok = ins_ok;
      default:   op_ok = acc_ok;
    endcase
  end

  always_comb begin
    len_d = len_q;
    if (in_fire && op_ok) begin
      case (op)
        OP_INSERT: len_d = len_q + LEN_W'(1);
        OP_REMOVE: len_d = len_q - LEN_W'(1);
        default:   len_d = len_q;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [LEN_W-1:0]       idx;
    logic [ENTRY_WIDTH-1:0] prev;
    logic [ENTRY_WIDTH-1:0] next;

    assign idx = LEN_W'(i);

    if (i == 0) begin : g_first
      assign prev = entry[i];
    end else begin : g_mid_prev
      assign prev = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next = entry[i];
    end else begin : g_mid_next
      assign next = entry[i+1];
    end

    always_comb begin
      ctrl[i].cmd  = CELL_HOLD;
      ctrl[i].data = data_in;
      if (in_fire && op_ok) begin
        case (op)
          OP_INSERT: begin
            if (idx == position_i) begin
              ctrl[i].cmd = CELL_LOAD;
            end else if ((idx > position_i) && (idx <= len_q)) begin
              ctrl[i].cmd = CELL_TAKE_PREV;
            end
          end
          OP_REMOVE: begin
            if ((idx >= position_i) && ((idx + LEN_W'(1)) < len_q)) begin
              ctrl[i].cmd = CELL_TAKE_NEXT;
            end
          end
          OP_SET: begin
            if (idx == position_i) begin
              ctrl[i].cmd = CELL_LOAD;
            end
          end
          default: ctrl[i].cmd = CELL_HOLD;
        endcase
      end
    end

    plist_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (entry[i])
    );
  end

  assign rd_entry = entry[position_i[IDX_W-1:0]];
  assign rd_val   = (op == OP_GET && acc_ok) ? DATA_W'(rd_entry) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      len_q <= len_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q    <= op_ok;
      rd_q    <= rd_val;
      count_q <= len_d;
      full_q  <= (len_d >= cap_eff);
      empty_q <= (len_d == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign read_value_o = rd_q;
  assign count_o      = count_q;
  assign full_res_o   = full_q;
  assign empty_res_o  = empty_q;

`ifndef SYNTHESIS
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= DEPTH_LEN)
    else $error("list length exceeds depth");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op == OP_INSERT) && ins_ok |=> len_q == $past(len_q) + LEN_W'(1))
    else $error("accepted insert did not grow the list");

  a_remove_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op == OP_REMOVE) && (len_q == '0) |=> !ok_q && (count_q == '0))
    else $error("remove on empty list not rejected");

  a_result_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q && (count_q == len_q) && (empty_q == (len_q == '0)))
    else $error("result count does not match length");
`endif

endmodule

[tb/positional_list_insert_remove_test.sv]
// Testbench for positional_list_insert_remove: a short directed list, then random
// phases over many capacity settings, checked against a list mirror in a scoreboard class.
// Depends on plist_pkg and the positional_list_insert_remove RTL.
`timescale 1ns / 1ps

module positional_list_insert_remove_test;
  import plist_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam logic [LEN_W-1:0] PHASE_CAPS [12] = '{
    5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd17, 5'd9, 5'd2, 5'd16, 5'd12, 5'd3, 5'd16
  };

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]  count;
    logic              full_res;
    logic              empty_res;
  } outcome_t;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_PERIODIC,
    READY_RARELY
  } stall_e;

  class list_mirror;
    logic [ENTRY_WIDTH-1:0] cells [DEPTH];
    int unsigned length;
    int unsigned cap_limit;
    int unsigned mismatches;
    outcome_t expected_outcomes [$];

    function new();
      length = 0;
      cap_limit = CAP_RESET;
      mismatches = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void note_beat(op_e op, logic [LEN_W-1:0] pos, logic [DATA_W-1:0] data);
      outcome_t res;
      int unsigned cap;
      int unsigned idx;
      res = '0;
      cap = (cap_limit > DEPTH) ? DEPTH : cap_limit;
      res.ok = !(pos > length || pos == cap);
      if (res.ok) begin
        if (op == OP_INSERT) begin
          if (length >= cap) begin
            res.ok = 1'b0;
          end else begin
            for (idx = length; idx > pos; idx--) cells[idx] = cells[idx-1];
            cells[pos] = data[ENTRY_WIDTH-1:0];
            length++;
          end
        end else if (pos >= length) begin
          res.ok = 1'b0;
        end else begin
          case (op)
            OP_REMOVE: begin
              for (idx = pos; idx + 1 < length; idx++) cells[idx] = cells[idx+1];
              length--;
            end
            OP_SET: cells[pos] = data[ENTRY_WIDTH-1:0];
            default: res.read_value = DATA_W'(cells[pos]);
          endcase
        end
      end
      res.count = LEN_W'(length);
      res.full_res = (length >= cap);
      res.empty_res = (length == 0);
      expected_outcomes.push_back(res);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result beat with no operation pending");
        mismatches++;
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
        compare_field("read_value", want.read_value, got.read_value);
        compare_field("count", DATA_W'(want.count), DATA_W'(got.count));
        compare_field("full_res", DATA_W'(want.full_res), DATA_W'(got.full_res));
        compare_field("empty_res", DATA_W'(want.empty_res), DATA_W'(got.empty_res));
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i = OP_INSERT;
  logic [LEN_W-1:0]  position_i = '0;
  logic [DATA_W-1:0] entry_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              ok_o;
  logic [DATA_W-1:0] read_value_o;
  logic [LEN_W-1:0]  count_o;
  logic              full_res_o;
  logic              empty_res_o;

  list_mirror  mirror = new();
  int unsigned burst_left = 0;

  positional_list_insert_remove dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .position_i   (position_i),
    .entry_data_i (entry_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .full_res_o   (full_res_o),
    .empty_res_o  (empty_res_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic push_beat(input op_e op, input logic [LEN_W-1:0] pos,
                           input logic [DATA_W-1:0] data);
    int unsigned idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
      idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (idle > 0) begin
        in_valid_i <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    position_i   <= pos;
    entry_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.note_beat(op, pos, data);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [LEN_W-1:0] cap);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (mirror.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mirror.cap_limit = cap;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] cap, input int unsigned n_items);
    int unsigned w_ins;
    int unsigned w_rem;
    int unsigned pick;
    op_e op;
    logic [LEN_W-1:0] pos;
    w_ins = $urandom_range(15, 60);
    w_rem = $urandom_range(10, 35);
    write_capacity(cap);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < w_ins) op = OP_INSERT;
      else if (pick < w_ins + w_rem) op = OP_REMOVE;
      else if (pick[0]) op = OP_SET;
      else op = OP_GET;
      pick = $urandom_range(0, 9);
      if (pick < 7) pos = LEN_W'($urandom_range(0, mirror.length));
      else if (pick == 7) pos = LEN_W'(mirror.length + 1);
      else if (pick == 8) pos = LEN_W'(mirror.cap_limit);
      else pos = LEN_W'($urandom);
      push_beat(op, pos, $urandom);
    end
  endtask

  initial begin : stimulus
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_beat(OP_GET,    5'd0,  32'h1234_5678);
    push_beat(OP_REMOVE, 5'd0,  32'h0);
    push_beat(OP_SET,    5'd0,  32'hFFFF_FFFF);
    push_beat(OP_INSERT, 5'd1,  32'h0000_0001);
    push_beat(OP_INSERT, 5'd0,  32'hFFFF_FFFF);
    push_beat(OP_INSERT, 5'd0,  32'h0000_0000);
    push_beat(OP_INSERT, 5'd2,  32'hA5A5_A5A5);
    push_beat(OP_INSERT, 5'd1,  32'h5A5A_5A5A);
    push_beat(OP_GET,    5'd0,  32'hFFFF_FFFF);
    push_beat(OP_GET,    5'd1,  32'h0);
    push_beat(OP_GET,    5'd2,  32'h0);
    push_beat(OP_GET,    5'd3,  32'h0);
    push_beat(OP_SET,    5'd3,  32'h8000_0001);
    push_beat(OP_GET,    5'd3,  32'h0);
    push_beat(OP_GET,    5'd4,  32'h0);
    push_beat(OP_INSERT, 5'd31, 32'hDEAD_BEEF);
    push_beat(OP_REMOVE, 5'd1,  32'hFFFF_FFFF);
    push_beat(OP_GET,    5'd1,  32'h0);
    push_beat(OP_REMOVE, 5'd2,  32'h0);
    push_beat(OP_SET,    5'd31, 32'h0);
    push_beat(OP_GET,    5'd16, 32'h0);

    foreach (PHASE_CAPS[i]) run_phase(PHASE_CAPS[i], PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (mirror.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mirror.mismatches == 0) begin
      $display("positional_list_insert_remove_test: clean");
    end else begin
      $display("positional_list_insert_remove_test: errors");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned tick;
    stall_e mode;
    outcome_t got;
    tick = 0;
    mode = READY_ALWAYS;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {ok_o, read_value_o, count_o, full_res_o, empty_res_o};
        mirror.check_beat(got);
      end
      @(negedge clk_i);
      if (tick % 96 == 0) mode = stall_e'($urandom_range(0, 3));
      tick++;
      case (mode)
        READY_ALWAYS:   out_ready_i <= 1'b1;
        READY_MOSTLY:   out_ready_i <= ($urandom_range(0, 3) != 0);
        READY_PERIODIC: out_ready_i <= ((tick % 5) >= 2);
        default:        out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("positional_list_insert_remove_test: errors");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
hdl/plist_pkg.sv
hdl/plist_cell.sv
hdl/positional_list_insert_remove.sv
tb/positional_list_insert_remove_test.sv
